// ===== rtl/core/csd_pkg.sv =====
// Shared types, constants and helpers of the cursor sprite decoder.
// No dependencies; every module of the block imports this package.
`timescale 1ns / 1ps

package csd_pkg;

    // Sprite geometry
    localparam int SPRITE_SPAN = 256;
    localparam int OFS_W       = $clog2(SPRITE_SPAN);
    localparam logic [OFS_W-1:0] OFS_MAX = OFS_W'(SPRITE_SPAN - 1);

    // Field widths
    localparam int BYTE_W  = 8;
    localparam int BASE_W  = 12;
    localparam int COORD_W = 13;
    localparam int VALUE_W = 32;
    localparam int SLOTS   = 4;
    localparam int OUT_W   = 64;

    // Pixel codes
    localparam logic [1:0] CODE_BLACK = 2'b11;
    localparam logic [1:0] CODE_WHITE = 2'b00;
    localparam logic [1:0] CODE_END   = 2'b10;
    localparam logic [1:0] CODE_SKIP  = 2'b01;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLACK  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WHITE  = 2'd3;

    // Job queue
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // One decoded byte: which slots draw, their colors and columns, the row
    typedef struct packed {
        logic [SLOTS-1:0]            draw;
        logic [SLOTS-1:0]            black;
        logic [SLOTS-1:0][OFS_W-1:0] col;
        logic [OFS_W-1:0]            row;
    } t_job;

    // Configuration registers as seen by the pixel side
    typedef struct packed {
        logic [BASE_W-1:0]  base_x;
        logic [BASE_W-1:0]  base_y;
        logic [VALUE_W-1:0] black_value;
        logic [VALUE_W-1:0] white_value;
    } t_cfg;

    // Advance an offset, holding at the sprite edge
    function automatic logic [OFS_W-1:0] sat_inc(input logic [OFS_W-1:0] v);
        return (v >= OFS_MAX) ? OFS_MAX : v + 1'b1;
    endfunction

endpackage

// ===== rtl/core/csd_front.sv =====
// Front part: accepts sprite bytes, walks the four codes and tracks offsets.
// Depends on csd_pkg; feeds a t_job per byte with drawn pixels to csd_queue.
`timescale 1ns / 1ps

module csd_front
    import csd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic              i_start,
    input  logic              i_full,
    output logic              o_push,
    output t_job              o_job
);

    logic [OFS_W-1:0] r_col, n_col;
    logic [OFS_W-1:0] r_row, n_row;
    logic             w_accept;

    assign o_ready  = !i_full;
    assign w_accept = i_valid && !i_full;

    // Walk the codes, most significant pair first, stop at end of line
    always_comb begin
        logic [OFS_W-1:0] c;
        logic [1:0]       code;
        logic             ended;
        c     = i_start ? '0 : r_col;
        n_row = i_start ? '0 : r_row;
        ended = 1'b0;
        o_job = '0;
        o_job.row = n_row;
        for (int k = 0; k < SLOTS; k++) begin
            code = i_byte[BYTE_W-1-2*k -: 2];
            if (!ended) begin
                if (code == CODE_END) begin
                    ended = 1'b1;
                    c     = '0;
                    n_row = sat_inc(n_row);
                end else begin
                    if (code == CODE_BLACK || code == CODE_WHITE) begin
                        o_job.draw[k]  = 1'b1;
                        o_job.black[k] = (code == CODE_BLACK);
                        o_job.col[k]   = c;
                    end
                    c = sat_inc(c);
                end
            end
        end
        n_col = c;
    end

    // Queue only bytes that draw something
    assign o_push = w_accept && (|o_job.draw);

    // Hold offsets between bytes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (w_accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

// ===== rtl/core/csd_queue.sv =====
// Short job queue between the front and the pixel side.
// Depends on csd_pkg for t_job and the depth constants.
`timescale 1ns / 1ps

module csd_queue
    import csd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_job
);

    t_job              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_count;
    logic              w_pop;

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rptr];
    assign w_pop   = i_pop && o_valid;

    // Store job entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (w_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/core/csd_back.sv =====
// Pixel side: takes jobs from the queue and emits one pixel item per cycle while the output is not stalled.
// Depends on csd_pkg; drives the output register of the block.
`timescale 1ns / 1ps

module csd_back
    import csd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_q_valid,
    input  t_job               i_q_job,
    output logic               o_q_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [COORD_W-1:0] o_x,
    output logic [COORD_W-1:0] o_y,
    output logic [VALUE_W-1:0] o_value,
    output logic               o_last
);

    t_job               r_cur;
    logic               r_cur_valid;
    logic               r_out_valid;
    logic [COORD_W-1:0] r_x;
    logic [COORD_W-1:0] r_y;
    logic [VALUE_W-1:0] r_value;
    logic               r_last;

    logic                      w_adv;
    logic [$clog2(SLOTS)-1:0]  w_sel;
    logic [SLOTS-1:0]          w_rem;
    logic                      w_fin;
    logic                      w_load;

    // Pick the first slot still to draw
    always_comb begin
        w_sel = '0;
        for (int k = SLOTS - 1; k >= 0; k--) begin
            if (r_cur.draw[k]) begin
                w_sel = k[$clog2(SLOTS)-1:0];
            end
        end
        w_rem = r_cur.draw & ~(SLOTS'(1) << w_sel);
    end

    assign w_adv   = !r_out_valid || i_ready;
    assign w_fin   = r_cur_valid && (w_rem == '0);
    assign w_load  = w_adv && (!r_cur_valid || w_fin);
    assign o_q_pop = w_load && i_q_valid;

    // Step through the current job, load the next as the last pixel goes out
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_cur_valid;
            if (w_load) begin
                r_cur_valid <= i_q_valid;
            end
        end
    end

    // Payload: current job and the output register
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            if (w_load) begin
                r_cur <= i_q_job;
            end else begin
                r_cur.draw <= w_rem;
            end
            r_x     <= COORD_W'(i_cfg.base_x) + COORD_W'(r_cur.col[w_sel]);
            r_y     <= COORD_W'(i_cfg.base_y) + COORD_W'(r_cur.row);
            r_value <= r_cur.black[w_sel] ? i_cfg.black_value : i_cfg.white_value;
            r_last  <= w_fin;
        end
    end

    assign o_valid = r_out_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_value = r_value;
    assign o_last  = r_last;

endmodule

// ===== rtl/core/cursor_sprite_decoder_top.sv =====
// Top level of the cursor sprite decoder: configuration registers and the
// front, queue and pixel side. Depends on csd_pkg, csd_front, csd_queue, csd_back.
//
//  channel   dir  handshake                  payload
//  s (byte)  in   i_s_tvalid / o_s_tready    tdata: sprite_byte; tuser: start_of_sprite
//  m (pixel) out  o_m_tvalid / i_m_tready    tdata: pixel_x, pixel_y, pixel_value; tlast
//  cfg       in   i_cfg_we                   i_cfg_idx, i_cfg_data
//
// A byte is taken whenever the job queue is not full; its drawn pixels leave
// one per cycle while the output is not stalled. On its way out, a drawing
// byte passes the job queue, the current-job register and the output register.
// Up to four drawing bytes wait in the job queue; o_s_tready falls when it is full.
// Synchronous reset clears offsets, queue and valid flags and loads the
// configuration reset values.
`timescale 1ns / 1ps

module cursor_sprite_decoder_top
    import csd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [BYTE_W-1:0]    i_s_tdata,   // [7:0] sprite_byte
    input  logic                 i_s_tuser,   // [0] start_of_sprite
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [OUT_W-1:0]     o_m_tdata,   // [12:0] pixel_x, [25:13] pixel_y,
                                              // [57:26] pixel_value, [63:58] zero
    output logic                 o_m_tlast,   // last_of_byte
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [VALUE_W-1:0]   i_cfg_data
);

    t_cfg               r_cfg;
    logic               w_full;
    logic               w_push;
    t_job               w_push_job;
    logic               w_q_valid;
    t_job               w_q_job;
    logic               w_q_pop;
    logic [COORD_W-1:0] w_x;
    logic [COORD_W-1:0] w_y;
    logic [VALUE_W-1:0] w_value;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.base_x      <= '0;
            r_cfg.base_y      <= '0;
            r_cfg.black_value <= '0;
            r_cfg.white_value <= '1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_BASE_X: r_cfg.base_x      <= i_cfg_data[BASE_W-1:0];
                CFG_BASE_Y: r_cfg.base_y      <= i_cfg_data[BASE_W-1:0];
                CFG_BLACK:  r_cfg.black_value <= i_cfg_data;
                CFG_WHITE:  r_cfg.white_value <= i_cfg_data;
                default:    ;
            endcase
        end
    end

    csd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_byte  (i_s_tdata),
        .i_start (i_s_tuser),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_job   (w_push_job)
    );

    csd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .o_full  (w_full),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_job   (w_q_job)
    );

    csd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (w_q_valid),
        .i_q_job   (w_q_job),
        .o_q_pop   (w_q_pop),
        .o_valid   (o_m_tvalid),
        .i_ready   (i_m_tready),
        .o_x       (w_x),
        .o_y       (w_y),
        .o_value   (w_value),
        .o_last    (o_m_tlast)
    );

    // Pack the pixel item, pad to whole bytes
    assign o_m_tdata = {(OUT_W - 2*COORD_W - VALUE_W)'(0), w_value, w_y, w_x};

endmodule

// ===== rtl/core/csd_checker.sv =====
// Port-level checks of the cursor sprite decoder, bound to the top level.
// Depends on csd_pkg and cursor_sprite_decoder_top.
`timescale 1ns / 1ps

module csd_checker
    import csd_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_s_tready,
    input logic                 o_m_tvalid,
    input logic                 i_m_tready,
    input logic [OUT_W-1:0]     o_m_tdata,
    input logic                 o_m_tlast
);

    // Hold a stalled pixel item
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=>
            o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("stalled pixel item changed");

    // Drop output valid after reset
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("pixel valid after reset");

    // Queue is empty after reset, so the input side is ready
    a_rst_in: assert property (@(posedge i_clk)
        !i_rst_n |=> o_s_tready)
        else $error("input not ready after reset");

    // Padding bits stay zero
    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[OUT_W-1:2*COORD_W+VALUE_W] == '0))
        else $error("pixel item padding not zero");

endmodule

bind cursor_sprite_decoder_top csd_checker u_csd_checker (.*);

// ===== tb/cursor_sprite_decoder_top_tb.sv =====
// Self-checking testbench for cursor_sprite_decoder_top: sprite bytes in, pixel writes out,
// each pixel checked against a behavioral decoder kept in the bench.
// Depends on csd_pkg and the RTL of the block.
`timescale 1ns / 1ps

module cursor_sprite_decoder_top_tb;
    import csd_pkg::*;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              start;
    } t_sprite_item;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [VALUE_W-1:0] value;
        logic               last;
    } t_pixel;

    localparam int PAD_LO    = 2 * COORD_W + VALUE_W;
    localparam int HOLD_LEN  = 120;
    localparam int SETTLE    = 10;

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 i_s_tvalid = 1'b0;
    logic                 o_s_tready;
    logic [BYTE_W-1:0]    i_s_tdata  = '0;
    logic                 i_s_tuser  = 1'b0;
    logic                 o_m_tvalid;
    logic                 i_m_tready = 1'b0;
    logic [OUT_W-1:0]     o_m_tdata;
    logic                 o_m_tlast;
    logic                 i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx  = CFG_BASE_X;
    logic [VALUE_W-1:0]   i_cfg_data = '0;

    cursor_sprite_decoder_top DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Bench copy of the configuration and the sprite position
    logic [BASE_W-1:0]  shadow_base_x = '0;
    logic [BASE_W-1:0]  shadow_base_y = '0;
    logic [VALUE_W-1:0] shadow_black  = '0;
    logic [VALUE_W-1:0] shadow_white  = '1;
    logic [OFS_W-1:0]   col_ofs       = '0;
    logic [OFS_W-1:0]   row_ofs       = '0;

    t_sprite_item byte_queue[$];
    t_pixel       pending_pixels[$];
    int           n_errors = 0;

    // Idling controls, set by the stimulus between phases
    int tx_max_gap   = 0;
    int rx_max_stall = 0;
    int tx_gap_left  = 0;
    int rx_stall_left = 0;
    int rx_hold_reqs = 0;
    int rx_hold_seen = 0;
    int rx_hold_left = 0;
    logic rx_ready_nxt;
    t_sprite_item tx_item;
    t_pixel       got_pixel;
    t_pixel       want_pixel;

    always #5 i_clk = ~i_clk;

    // Advance an offset, holding at the last column or row of the sprite
    function automatic logic [OFS_W-1:0] step_ofs(input logic [OFS_W-1:0] v);
        if (v == OFS_W'(SPRITE_SPAN - 1))
            return v;
        return v + 1'b1;
    endfunction

    // Walk the four codes of an accepted byte and queue the pixels it draws
    task automatic decode_sprite_byte(input logic [BYTE_W-1:0] b, input logic start);
        t_pixel     px[SLOTS];
        int         n;
        logic       line_done;
        logic [1:0] code;
        n = 0;
        line_done = 1'b0;
        if (start) begin
            col_ofs = '0;
            row_ofs = '0;
        end
        for (int k = 0; k < SLOTS; k++) begin
            code = 2'(b >> (6 - 2 * k));
            if (!line_done) begin
                if (code == CODE_END) begin
                    col_ofs   = '0;
                    row_ofs   = step_ofs(row_ofs);
                    line_done = 1'b1;
                end else begin
                    if (code == CODE_BLACK || code == CODE_WHITE) begin
                        px[n].x     = COORD_W'(shadow_base_x) + COORD_W'(col_ofs);
                        px[n].y     = COORD_W'(shadow_base_y) + COORD_W'(row_ofs);
                        px[n].value = (code == CODE_BLACK) ? shadow_black : shadow_white;
                        px[n].last  = 1'b0;
                        n++;
                    end
                    col_ofs = step_ofs(col_ofs);
                end
            end
        end
        if (n > 0)
            px[n-1].last = 1'b1;
        for (int j = 0; j < n; j++)
            pending_pixels.push_back(px[j]);
    endtask

    // Sender: offer queued bytes, with a random gap drawn after each accepted one
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (!i_s_tvalid || o_s_tready) begin
            if (i_s_tvalid)
                tx_gap_left = $urandom_range(0, tx_max_gap);
            if (tx_gap_left > 0 || byte_queue.size() == 0) begin
                if (tx_gap_left > 0)
                    tx_gap_left--;
                i_s_tvalid <= 1'b0;
            end else begin
                tx_item = byte_queue.pop_front();
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= tx_item.data;
                i_s_tuser  <= tx_item.start;
            end
        end
    end

    // Receiver: random stall after each pixel, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (rx_hold_reqs != rx_hold_seen) begin
                rx_hold_seen = rx_hold_reqs;
                rx_hold_left = HOLD_LEN;
            end
            if (o_m_tvalid && i_m_tready)
                rx_stall_left = $urandom_range(0, rx_max_stall);
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                rx_ready_nxt = 1'b0;
            end else if (rx_stall_left > 0) begin
                rx_stall_left--;
                rx_ready_nxt = 1'b0;
            end else begin
                rx_ready_nxt = 1'b1;
            end
            i_m_tready <= rx_ready_nxt;
        end
    end

    // Check each accepted pixel against the oldest expectation, then predict new bytes
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                got_pixel.x     = o_m_tdata[COORD_W-1:0];
                got_pixel.y     = o_m_tdata[2*COORD_W-1:COORD_W];
                got_pixel.value = o_m_tdata[PAD_LO-1:2*COORD_W];
                got_pixel.last  = o_m_tlast;
                if (pending_pixels.size() == 0) begin
                    $error("unexpected pixel: x %0d y %0d value %h", got_pixel.x,
                           got_pixel.y, got_pixel.value);
                    n_errors++;
                end else begin
                    want_pixel = pending_pixels.pop_front();
                    if (got_pixel.x !== want_pixel.x) begin
                        $error("pixel_x: expected %0d, got %0d", want_pixel.x, got_pixel.x);
                        n_errors++;
                    end
                    if (got_pixel.y !== want_pixel.y) begin
                        $error("pixel_y: expected %0d, got %0d", want_pixel.y, got_pixel.y);
                        n_errors++;
                    end
                    if (got_pixel.value !== want_pixel.value) begin
                        $error("pixel_value: expected %h, got %h", want_pixel.value,
                               got_pixel.value);
                        n_errors++;
                    end
                    if (got_pixel.last !== want_pixel.last) begin
                        $error("last_of_byte: expected %0d, got %0d", want_pixel.last,
                               got_pixel.last);
                        n_errors++;
                    end
                end
                if (o_m_tdata[OUT_W-1:PAD_LO] !== '0) begin
                    $error("tdata pad: expected 0, got %h", o_m_tdata[OUT_W-1:PAD_LO]);
                    n_errors++;
                end
            end
            if (i_s_tvalid && o_s_tready)
                decode_sprite_byte(i_s_tdata, i_s_tuser);
        end
    end

    task automatic push_byte(input logic [BYTE_W-1:0] b, input logic start);
        t_sprite_item it;
        it.data  = b;
        it.start = start;
        byte_queue.push_back(it);
    endtask

    function automatic logic [1:0] draw_or_skip();
        case ($urandom_range(0, 2))
            0:       return CODE_BLACK;
            1:       return CODE_WHITE;
            default: return CODE_SKIP;
        endcase
    endfunction

    // Byte of four codes none of which ends the line
    task automatic push_drawing_byte(input logic start);
        logic [BYTE_W-1:0] b;
        for (int j = 0; j < SLOTS; j++)
            b = {b[BYTE_W-3:0], draw_or_skip()};
        push_byte(b, start);
    endtask

    // One sprite row: now and then a full byte, then a byte ending the line at a
    // random slot; codes after the end are random and must be ignored
    task automatic push_row(input logic first);
        logic [BYTE_W-1:0] b;
        int                k;
        if ($urandom_range(0, 15) == 0) begin
            push_drawing_byte(first);
            first = 1'b0;
        end
        k = $urandom_range(0, SLOTS - 1);
        b = BYTE_W'($urandom);
        for (int j = 0; j < k; j++)
            b[7 - 2 * j -: 2] = draw_or_skip();
        b[7 - 2 * k -: 2] = CODE_END;
        push_byte(b, first);
    endtask

    // Wait until every byte is taken and every pixel has come out
    task automatic drain();
        @(negedge i_clk);
        while (byte_queue.size() != 0 || i_s_tvalid || pending_pixels.size() != 0)
            @(negedge i_clk);
    endtask

    // Reprogram all four registers; the block is idle here
    task automatic set_config(input logic [BASE_W-1:0] bx, input logic [BASE_W-1:0] by,
                              input logic [VALUE_W-1:0] blk, input logic [VALUE_W-1:0] wht);
        logic [VALUE_W-1:0] vals[SLOTS];
        logic [CFG_IDX_W-1:0] idxs[SLOTS];
        repeat (SETTLE) @(posedge i_clk);
        vals[0] = VALUE_W'(bx);
        vals[1] = VALUE_W'(by);
        vals[2] = blk;
        vals[3] = wht;
        idxs[0] = CFG_BASE_X;
        idxs[1] = CFG_BASE_Y;
        idxs[2] = CFG_BLACK;
        idxs[3] = CFG_WHITE;
        for (int j = 0; j < SLOTS; j++) begin
            @(posedge i_clk);
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idxs[j];
            i_cfg_data <= vals[j];
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        shadow_base_x = bx;
        shadow_base_y = by;
        shadow_black  = blk;
        shadow_white  = wht;
    endtask

    task automatic begin_phase(input int tx_gap, input int rx_stall);
        @(negedge i_clk);
        tx_max_gap   = tx_gap;
        rx_max_stall = rx_stall;
    endtask

    // Stimulus
    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed bytes with the reset configuration
        begin_phase(14, 14);
        push_byte(8'hFF, 1'b1);  // four black
        push_byte(8'h00, 1'b0);  // four white
        push_byte(8'h55, 1'b0);  // all transparent, no pixel
        push_byte(8'hAA, 1'b0);  // line end in the first slot
        push_byte(8'hE4, 1'b0);  // black, end, rest ignored
        push_byte(8'h1B, 1'b0);  // white, skip, end, black ignored
        push_byte(8'h27, 1'b0);
        push_byte(8'hD8, 1'b0);
        push_byte(8'h3C, 1'b0);
        push_byte(8'h80, 1'b0);  // end then white codes that must not draw
        push_byte(8'h7F, 1'b0);
        push_byte(8'h02, 1'b0);  // end in the last slot
        push_byte(8'hC3, 1'b1);  // start flag mid-stream clears both offsets
        push_byte(8'h6A, 1'b0);
        push_byte(8'h5D, 1'b0);
        push_byte(8'h00, 1'b1);
        drain();

        // Sprite at the far corner: a long line saturates the column offset
        set_config('1, '1, '1, '0);
        begin_phase(2, 14);
        rx_hold_reqs++;
        for (int r = 0; r < 100; r++) begin
            if (r == 40)
                for (int j = 0; j < 66; j++)
                    push_drawing_byte(1'b0);
            push_row(r == 0);
        end
        drain();
        begin_phase(6, 8);
        for (int r = 100; r < 130; r++)
            push_row(1'b0);
        drain();

        // Short sprites with no idling on either side
        set_config(BASE_W'($urandom), BASE_W'($urandom), $urandom, $urandom);
        begin_phase(0, 0);
        for (int s = 0; s < 3; s++)
            for (int r = 0; r < 7; r++)
                push_row(r == 0);
        drain();

        // Random bytes and start flags at the origin
        set_config('0, '0, $urandom, $urandom);
        begin_phase(14, 0);
        for (int j = 0; j < 32; j++)
            push_byte(BYTE_W'($urandom), $urandom_range(0, 7) == 0);
        drain();

        repeat (SETTLE) @(posedge i_clk);
        if (n_errors == 0)
            $display("cursor_sprite_decoder_top_tb: clean");
        else
            $display("cursor_sprite_decoder_top_tb: errors");
        $finish;
    end

    // Run limit
    initial begin
        #4_000_000;
        $display("cursor_sprite_decoder_top_tb: errors");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/csd_pkg.sv
rtl/core/csd_front.sv
rtl/core/csd_queue.sv
rtl/core/csd_back.sv
rtl/core/cursor_sprite_decoder_top.sv
rtl/core/csd_checker.sv
tb/cursor_sprite_decoder_top_tb.sv
